### hw/rtl/box_overlap_ratio_core_macros.svh
// ----------------------------------------------------------------------------
// Box overlap ratio core: assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BOX_OVERLAP_RATIO_CORE_MACROS_SVH
`define BOX_OVERLAP_RATIO_CORE_MACROS_SVH

// Implication checked at every rising edge of clk_i outside reset.
`define BOR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define BOR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### hw/rtl/bor_pkg.sv
// ----------------------------------------------------------------------------
// Box overlap ratio package
// Default sizes, mode codes and the control group passed along the pipeline.
// ----------------------------------------------------------------------------
package bor_pkg;

  localparam int CoordBitsDefault = 14;
  localparam int FracBitsDefault  = 16;

  typedef enum logic {
    MODE_IOU = 1'b0,
    MODE_IOS = 1'b1
  } overlap_mode_e;

  typedef struct packed {
    logic valid;
    logic bad;
  } bor_ctl_t;

endpackage

### hw/rtl/box_overlap_ratio_core.sv
// ----------------------------------------------------------------------------
// Box overlap ratio core
// Intersection over union / over smaller area of two boxes, Q1.FRAC_BITS.
// ----------------------------------------------------------------------------
// Accepts one box pair per cycle while the output is not stalled and returns
// one result per request, in order. Three front-end stages (edge differences,
// area multiplies, denominator select) then a row of FRAC_BITS + 1 divider
// cells, one quotient bit each, the last cell acting as output register.
// Each stage holds its item until the next one frees up, so gaps close up
// when the output stalls. bad_denominator forces ratio to zero.
module box_overlap_ratio_core #(
  parameter int COORD_BITS = bor_pkg::CoordBitsDefault,
  parameter int FRAC_BITS  = bor_pkg::FracBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom
  input  logic [((8*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // mode
  input  logic s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // ratio, overlap_area
  output logic [((FRAC_BITS+1+2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // bad_denominator
  output logic m_axis_tuser_o
);

  localparam int OutBits  = ((FRAC_BITS + 1 + 2 * COORD_BITS + 7) / 8) * 8;
  localparam int AreaBits = 2 * COORD_BITS;
  localparam int RemBits  = 2 * COORD_BITS + 3;
  localparam int QuoBits  = FRAC_BITS + 1;
  localparam int Cells    = FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] RatioOne = {1'b1, {FRAC_BITS{1'b0}}};

  bor_pkg::bor_ctl_t   ctl_w  [Cells+1];
  logic                rdy_w  [Cells+1];
  logic [RemBits-1:0]  rem_w  [Cells+1];
  logic [RemBits-1:0]  den_w  [Cells+1];
  logic [QuoBits-1:0]  quo_w  [Cells+1];
  logic [AreaBits-1:0] area_w [Cells+1];
  logic [QuoBits-1:0]  ratio;

  bor_geom #(
    .COORD_BITS(COORD_BITS)
  ) u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid_i),
    .ready_o    (s_axis_tready_o),
    .mode_i     (s_axis_tuser_i),
    .a_left_i   (s_axis_tdata_i[0*COORD_BITS +: COORD_BITS]),
    .a_top_i    (s_axis_tdata_i[1*COORD_BITS +: COORD_BITS]),
    .a_right_i  (s_axis_tdata_i[2*COORD_BITS +: COORD_BITS]),
    .a_bottom_i (s_axis_tdata_i[3*COORD_BITS +: COORD_BITS]),
    .b_left_i   (s_axis_tdata_i[4*COORD_BITS +: COORD_BITS]),
    .b_top_i    (s_axis_tdata_i[5*COORD_BITS +: COORD_BITS]),
    .b_right_i  (s_axis_tdata_i[6*COORD_BITS +: COORD_BITS]),
    .b_bottom_i (s_axis_tdata_i[7*COORD_BITS +: COORD_BITS]),
    .ctl_o      (ctl_w[0]),
    .ready_i    (rdy_w[0]),
    .den_o      (den_w[0]),
    .area_o     (area_w[0])
  );

  // remainder starts at the overlap area, which never exceeds a good denominator
  assign rem_w[0] = RemBits'(area_w[0]);
  assign quo_w[0] = '0;

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    bor_div_cell #(
      .REM_BITS  (RemBits),
      .AREA_BITS (AreaBits),
      .QUO_BITS  (QuoBits),
      .FIRST     (g == 0)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_w[g]),
      .ready_o (rdy_w[g]),
      .rem_i   (rem_w[g]),
      .den_i   (den_w[g]),
      .quo_i   (quo_w[g]),
      .area_i  (area_w[g]),
      .ctl_o   (ctl_w[g+1]),
      .ready_i (rdy_w[g+1]),
      .rem_o   (rem_w[g+1]),
      .den_o   (den_w[g+1]),
      .quo_o   (quo_w[g+1]),
      .area_o  (area_w[g+1])
    );
  end

  assign rdy_w[Cells] = m_axis_tready_i;
  assign ratio        = ctl_w[Cells].bad ? '0 : quo_w[Cells];

  assign m_axis_tvalid_o = ctl_w[Cells].valid;
  assign m_axis_tdata_o  = OutBits'({area_w[Cells], ratio});
  assign m_axis_tuser_o  = ctl_w[Cells].bad;

`include "box_overlap_ratio_core_macros.svh"

  `BOR_ASSERT_IMPL(a_bad_zero, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o[FRAC_BITS:0] == '0, "ratio not zero on bad denominator")
  `BOR_ASSERT_NEVER(a_ratio_max, m_axis_tvalid_o && (m_axis_tdata_o[FRAC_BITS:0] > RatioOne), "ratio above one")
  `BOR_ASSERT_IMPL(a_stall_src, !s_axis_tready_o, m_axis_tvalid_o && !m_axis_tready_i, "input stalled without output back-pressure")

endmodule

### hw/rtl/bor_geom.sv
// ----------------------------------------------------------------------------
// Box overlap ratio geometry front end
// Three stages: edge differences, areas and overlap area, denominator select.
// ----------------------------------------------------------------------------
module bor_geom #(
  parameter int COORD_BITS = bor_pkg::CoordBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic                      mode_i,
  input  logic [COORD_BITS-1:0]     a_left_i,
  input  logic [COORD_BITS-1:0]     a_top_i,
  input  logic [COORD_BITS-1:0]     a_right_i,
  input  logic [COORD_BITS-1:0]     a_bottom_i,
  input  logic [COORD_BITS-1:0]     b_left_i,
  input  logic [COORD_BITS-1:0]     b_top_i,
  input  logic [COORD_BITS-1:0]     b_right_i,
  input  logic [COORD_BITS-1:0]     b_bottom_i,
  output bor_pkg::bor_ctl_t         ctl_o,
  input  logic                      ready_i,
  output logic [2*COORD_BITS+2:0]   den_o,
  output logic [2*COORD_BITS-1:0]   area_o
);

  localparam int DiffBits = COORD_BITS + 1;
  localparam int ProdBits = 2 * COORD_BITS + 2;
  localparam int AreaBits = 2 * COORD_BITS;
  localparam int DenBits  = 2 * COORD_BITS + 3;

  // stage 1
  logic                       v1_q;
  logic                       rdy1;
  logic                       mode1_q;
  logic signed [DiffBits-1:0] aw_q, ah_q, bw_q, bh_q, ow_q, oh_q;
  logic signed [DiffBits-1:0] aw_d, ah_d, bw_d, bh_d, ow_d, oh_d;
  logic [COORD_BITS-1:0]      min_r, max_l, min_b, max_t;

  // stage 2
  logic                       v2_q;
  logic                       rdy2;
  logic                       mode2_q;
  logic signed [ProdBits-1:0] sa_q, sb_q, sa_d, sb_d;
  logic [AreaBits-1:0]        si2_q, si2_d;

  // stage 3
  logic                       v3_q;
  logic                       rdy3;
  logic                       bad3_q, bad3_d;
  logic signed [DenBits-1:0]  den3_q, den3_d;
  logic [AreaBits-1:0]        si3_q;
  logic signed [DenBits-1:0]  sa_x, sb_x, si_x;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_comb begin
    min_r = (a_right_i  <= b_right_i)  ? a_right_i  : b_right_i;
    max_l = (a_left_i   >= b_left_i)   ? a_left_i   : b_left_i;
    min_b = (a_bottom_i <= b_bottom_i) ? a_bottom_i : b_bottom_i;
    max_t = (a_top_i    >= b_top_i)    ? a_top_i    : b_top_i;
    aw_d  = $signed({1'b0, a_right_i})  - $signed({1'b0, a_left_i});
    ah_d  = $signed({1'b0, a_bottom_i}) - $signed({1'b0, a_top_i});
    bw_d  = $signed({1'b0, b_right_i})  - $signed({1'b0, b_left_i});
    bh_d  = $signed({1'b0, b_bottom_i}) - $signed({1'b0, b_top_i});
    ow_d  = $signed({1'b0, min_r}) - $signed({1'b0, max_l});
    oh_d  = $signed({1'b0, min_b}) - $signed({1'b0, max_t});
  end

  always_comb begin
    sa_d = ProdBits'(aw_q) * ProdBits'(ah_q);
    sb_d = ProdBits'(bw_q) * ProdBits'(bh_q);
    if (ow_q > 0 && oh_q > 0) begin
      si2_d = AreaBits'(ow_q[COORD_BITS-1:0]) * AreaBits'(oh_q[COORD_BITS-1:0]);
    end else begin
      si2_d = '0;
    end
  end

  always_comb begin
    sa_x = DenBits'(sa_q);
    sb_x = DenBits'(sb_q);
    si_x = $signed({3'b000, si2_q});
    if (mode2_q == bor_pkg::MODE_IOU) begin
      den3_d = sa_x + sb_x - si_x;
    end else begin
      den3_d = (sa_x <= sb_x) ? sa_x : sb_x;
    end
    bad3_d = den3_d[DenBits-1] || (den3_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      mode1_q <= mode_i;
      aw_q    <= aw_d;
      ah_q    <= ah_d;
      bw_q    <= bw_d;
      bh_q    <= bh_d;
      ow_q    <= ow_d;
      oh_q    <= oh_d;
    end
    if (rdy2 && v1_q) begin
      mode2_q <= mode1_q;
      sa_q    <= sa_d;
      sb_q    <= sb_d;
      si2_q   <= si2_d;
    end
    if (rdy3 && v2_q) begin
      den3_q <= den3_d;
      bad3_q <= bad3_d;
      si3_q  <= si2_q;
    end
  end

  assign ctl_o.valid = v3_q;
  assign ctl_o.bad   = bad3_q;
  assign den_o       = den3_q;
  assign area_o      = si3_q;

endmodule

### hw/rtl/bor_div_cell.sv
// ----------------------------------------------------------------------------
// Box overlap ratio divider cell
// One restoring division step: yields one quotient bit per cell.
// ----------------------------------------------------------------------------
module bor_div_cell #(
  parameter int REM_BITS  = 31,
  parameter int AREA_BITS = 28,
  parameter int QUO_BITS  = 17,
  parameter bit FIRST     = 1'b0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bor_pkg::bor_ctl_t     ctl_i,
  output logic                  ready_o,
  input  logic [REM_BITS-1:0]   rem_i,
  input  logic [REM_BITS-1:0]   den_i,
  input  logic [QUO_BITS-1:0]   quo_i,
  input  logic [AREA_BITS-1:0]  area_i,
  output bor_pkg::bor_ctl_t     ctl_o,
  input  logic                  ready_i,
  output logic [REM_BITS-1:0]   rem_o,
  output logic [REM_BITS-1:0]   den_o,
  output logic [QUO_BITS-1:0]   quo_o,
  output logic [AREA_BITS-1:0]  area_o
);

  bor_pkg::bor_ctl_t      ctl_q;
  logic                   load;
  logic                   ge;
  logic [REM_BITS-1:0]    trial;
  logic [REM_BITS-1:0]    rem_d, rem_q, den_q;
  logic [QUO_BITS-1:0]    quo_d, quo_q;
  logic [AREA_BITS-1:0]   area_q;

  assign load    = !ctl_q.valid || ready_i;
  assign ready_o = load;

  always_comb begin
    trial = FIRST ? rem_i : {rem_i[REM_BITS-2:0], 1'b0};
    ge    = (trial >= den_i);
    rem_d = ge ? (trial - den_i) : trial;
    quo_d = {quo_i[QUO_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (load) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && ctl_i.valid) begin
      rem_q  <= rem_d;
      den_q  <= den_i;
      quo_q  <= quo_d;
      area_q <= area_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign rem_o  = rem_q;
  assign den_o  = den_q;
  assign quo_o  = quo_q;
  assign area_o = area_q;

endmodule
